/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_CLK_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/core/sss_pkg.sv */
// Package: codes, widths and control types of the substring search block.
`timescale 1ns / 1ps
package sss_pkg;

    localparam int DATA_W   = 8;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_HAY    = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_FOUND = 2'd0,
        ST_FOUND     = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic clear;
        logic append;
    } needle_op_t;

endpackage

/* rtl/core/streaming_substring_search.sv */
// Top level: streaming first-occurrence substring search.
`timescale 1ns / 1ps
// A request passes through the input register and then the result register.
// One request per cycle unless m_tready stalls; the window compare is combinational.
// Reset: rst_n async, clears needle length, overflow, offset count and handshake state.
// Needle and window bytes have no reset; only written entries are ever compared.
module streaming_substring_search #(
    parameter int MAX_NEEDLE = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sss_pkg::DATA_W-1:0]       s_tdata,   // [7:0] data
    input  logic [sss_pkg::CMD_W-1:0]        s_tuser,   // [1:0] cmd
    input  logic                             s_tlast,   // last
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sss_pkg::OFFSET_W-1:0]     m_tdata,   // [31:0] offset
    output logic [sss_pkg::STATUS_W-1:0]     m_tuser    // [1:0] status
);
    import sss_pkg::*;

    `include "assert_macros.svh"

    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);

    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_last_reg;

    logic                  out_free;
    logic                  go;
    needle_op_t            nop;
    logic                  shift;
    logic [MAX_NEEDLE-1:0][DATA_W-1:0] needle;
    logic [LEN_W-1:0]      len;
    logic                  overflow;
    logic                  hit;

    logic [OFFSET_W-1:0]   bytes_seen_reg;
    logic [OFFSET_W-1:0]   bytes_seen_next;
    logic                  search_done_reg;
    logic                  search_done_next;
    logic [OFFSET_W-1:0]   bytes_inc;
    logic [OFFSET_W-1:0]   len_ext;
    logic                  emit;
    status_t               status;
    logic [OFFSET_W-1:0]   offset;

    logic                  m_tvalid_reg;
    status_t               m_status_reg;
    logic [OFFSET_W-1:0]   m_offset_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign go       = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign nop.clear  = go && (in_cmd_reg == CMD_CLEAR);
    assign nop.append = go && (in_cmd_reg == CMD_APPEND);
    assign shift      = go && (in_cmd_reg == CMD_HAY);

    sss_needle #(
        .MAX_NEEDLE (MAX_NEEDLE),
        .LEN_W      (LEN_W)
    ) u_needle (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (nop),
        .data     (in_data_reg),
        .needle   (needle),
        .len      (len),
        .overflow (overflow)
    );

    sss_window #(
        .MAX_NEEDLE (MAX_NEEDLE),
        .LEN_W      (LEN_W)
    ) u_window (
        .clk    (clk),
        .shift  (shift),
        .data   (in_data_reg),
        .needle (needle),
        .len    (len),
        .hit    (hit)
    );

    assign bytes_inc = (bytes_seen_reg == '1) ? bytes_seen_reg
                                              : bytes_seen_reg + OFFSET_W'(1);
    assign len_ext   = {{(OFFSET_W-LEN_W){1'b0}}, len};

    always_comb
    begin
        bytes_seen_next  = bytes_seen_reg;
        search_done_next = search_done_reg;
        emit             = 1'b0;
        status           = ST_NOT_FOUND;
        offset           = '0;
        if (go)
        begin
            unique case (in_cmd_reg) inside
                CMD_CLEAR, CMD_APPEND:
                begin
                    bytes_seen_next  = '0;
                    search_done_next = 1'b0;
                end
                CMD_HAY:
                begin
                    bytes_seen_next = bytes_inc;
                    if (!search_done_reg)
                    begin
                        if (overflow)
                        begin
                            status = ST_OVERFLOW;
                            emit   = 1'b1;
                        end
                        else if (len == '0)
                        begin
                            status = ST_FOUND;
                            emit   = 1'b1;
                        end
                        else if (hit && (bytes_inc >= len_ext))
                        begin
                            status = ST_FOUND;
                            offset = bytes_inc - len_ext;
                            emit   = 1'b1;
                        end
                        else if (in_last_reg)
                        begin
                            emit = 1'b1;
                        end
                    end
                    search_done_next = search_done_reg || emit;
                    if (in_last_reg)
                    begin
                        bytes_seen_next  = '0;
                        search_done_next = 1'b0;
                    end
                end
                default:
                begin
                    bytes_seen_next = bytes_seen_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            bytes_seen_reg  <= '0;
            search_done_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            bytes_seen_reg  <= bytes_seen_next;
            search_done_reg <= search_done_next;
            if (go && emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= cmd_t'(s_tuser);
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (go && emit)
        begin
            m_status_reg <= status;
            m_offset_reg <= offset;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_offset_reg;

    `ASSERT_CLK(a_offset_zero_unless_found, clk, rst_n,
        (m_tvalid && (m_tuser != ST_FOUND)) |-> (m_tdata == '0))
    `ASSERT_CLK(a_overflow_only_when_full, clk, rst_n,
        overflow |-> (len == LEN_W'(MAX_NEEDLE)))
    `ASSERT_CLK(a_clear_restarts_search, clk, rst_n,
        nop.clear |=> ((bytes_seen_reg == '0) && !search_done_reg && (len == '0)))

endmodule

/* rtl/core/sss_needle.sv */
// Needle shift store with length and overflow tracking.
`timescale 1ns / 1ps
module sss_needle #(
    parameter int MAX_NEEDLE = 64,
    parameter int LEN_W      = $clog2(MAX_NEEDLE + 1)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  sss_pkg::needle_op_t                     op,
    input  logic [sss_pkg::DATA_W-1:0]              data,
    output logic [MAX_NEEDLE-1:0][sss_pkg::DATA_W-1:0] needle,
    output logic [LEN_W-1:0]                        len,
    output logic                                    overflow
);
    import sss_pkg::*;

    logic [MAX_NEEDLE-1:0][DATA_W-1:0] needle_reg;
    logic [LEN_W-1:0]                  len_reg;
    logic [LEN_W-1:0]                  len_next;
    logic                              ovf_reg;
    logic                              ovf_next;
    logic                              full;
    logic                              store;

    assign full  = (len_reg == LEN_W'(MAX_NEEDLE));
    assign store = op.append && !full;

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (op.clear)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        else if (op.append)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    // newest appended byte sits at index 0
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            needle_reg[0] <= data;
            for (int k = 1; k < MAX_NEEDLE; k++)
            begin
                needle_reg[k] <= needle_reg[k-1];
            end
        end
    end

    assign needle   = needle_reg;
    assign len      = len_reg;
    assign overflow = ovf_reg;

endmodule

/* rtl/core/sss_window.sv */
// Haystack shift window with per-lane compare against the needle.
`timescale 1ns / 1ps
module sss_window #(
    parameter int MAX_NEEDLE = 64,
    parameter int LEN_W      = $clog2(MAX_NEEDLE + 1)
) (
    input  logic                                       clk,
    input  logic                                       shift,
    input  logic [sss_pkg::DATA_W-1:0]                 data,
    input  logic [MAX_NEEDLE-1:0][sss_pkg::DATA_W-1:0] needle,
    input  logic [LEN_W-1:0]                           len,
    output logic                                       hit
);
    import sss_pkg::*;

    logic [MAX_NEEDLE-1:0][DATA_W-1:0] window_reg;
    logic [MAX_NEEDLE-1:0]             lane_ok;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            window_reg[0] <= data;
            for (int k = 1; k < MAX_NEEDLE; k++)
            begin
                window_reg[k] <= window_reg[k-1];
            end
        end
    end

    // compare against the window as it stands after this byte shifts in
    for (genvar k = 0; k < MAX_NEEDLE; k++)
    begin : g_lane
        logic [DATA_W-1:0] cur;
        logic              active;
        if (k == 0)
        begin : g_head
            assign cur = data;
        end
        else
        begin : g_tail
            assign cur = window_reg[k-1];
        end
        assign active     = (LEN_W'(k) < len);
        assign lane_ok[k] = !active || (cur == needle[k]);
    end

    assign hit = &lane_ok;

endmodule
